>>> sv/spi_debug_port_master_core_defines.svh
// Assertion macros used by the checker file of the SPI debug port master.
`ifndef SPI_DEBUG_PORT_MASTER_CORE_DEFINES_SVH
`define SPI_DEBUG_PORT_MASTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDPM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SDPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/spdm_pkg.sv
// Types and constants of the SPI debug port master.
`default_nettype none

package spdm_pkg;

    localparam int WORD_BITS    = 16;
    localparam int BIT_CNT_W    = $clog2(WORD_BITS + 1);
    localparam int BIT_IDX_W    = $clog2(WORD_BITS);
    localparam int CMD_BITS     = 8;
    localparam int RESET_PULSES = 2;
    localparam int PERIOD_W     = 8;
    localparam int SEG_W        = 3;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 8;
    localparam int IN_DATA_W    = 56;
    localparam int OUT_DATA_W   = 24;

    // Bit positions inside the held pin level vector.
    localparam int PIN_MOSI = 0;
    localparam int PIN_CLK  = 1;
    localparam int PIN_MUX  = 2;
    localparam int PIN_CSB  = 3;

    // Segments of one bit slot, plus SEG_LAST; the closing sequence runs through all of them.
    localparam logic [SEG_W-1:0] SEG_SETUP = 3'd0;
    localparam logic [SEG_W-1:0] SEG_LOW   = 3'd1;
    localparam logic [SEG_W-1:0] SEG_HIGH  = 3'd2;
    localparam logic [SEG_W-1:0] SEG_LAST  = 3'd4;

    localparam logic [1:0] CMD_READ_TAG  = 2'b11;
    localparam logic [1:0] CMD_WRITE_TAG = 2'b10;

    localparam logic [PERIOD_W-1:0] SHIFT_PERIOD_RESET = 8'd1;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_RESET = 4'd1,
        PH_CMD   = 4'd2,
        PH_ADDR  = 4'd3,
        PH_ECHO  = 4'd4,
        PH_RDATA = 4'd5,
        PH_WAIT  = 4'd6,
        PH_WDATA = 4'd7,
        PH_END   = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_WORD  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_NORMAL   = 2'd0,
        ST_BUSY     = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_DONE     = 2'd3
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SHIFT_PERIOD = 3'd0,
        CFG_CMD_READ     = 3'd1,
        CFG_CMD_WRITE    = 3'd2,
        CFG_MUX_ENABLE   = 3'd3,
        CFG_MUX_CONFIG   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] data;
        logic [15:0] length;
        logic [15:0] address;
        logic        miso;
    } in_data_t;

    typedef struct packed {
        logic        busy_res;
        logic        want_data;
        logic        read_valid;
        logic [15:0] read_word;
        logic        mux_pin;
        logic        csb;
        logic        sclk;
        logic        mosi;
    } out_data_t;

    typedef struct packed {
        status_t   status;
        out_data_t data;
    } result_t;

endpackage

`default_nettype wire

>>> sv/spi_debug_port_master_core.sv
// Bit-level SPI master for a 16-bit debug port, one pin slot per tick.
//
//  Channel   Direction  Handshake                 Payload
//  s_axis    in         s_tvalid / s_tready       s_tuser action, s_tdata miso/addr/len/data
//  m_axis    out        m_tvalid / m_tready       m_tdata pins and read word, m_tuser status
//  cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Every input transaction is processed in the cycle it is accepted: the pin
// waveform state and the result are both written at that clock edge, so the
// block sustains one transaction per cycle while s_tready is high. A two-entry
// output stage (output register plus skid register) keeps the input open
// while a result waits; s_tready drops only when both are full. Reset is
// asynchronous and clears all control state; no clearing pass runs.
// The configuration port is always ready and must only be written while idle.
`default_nettype none

module spi_debug_port_master_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Input stream.
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // From bit 0: miso, address[15:0], length[15:0], data[15:0], zero pad.
    input  wire logic [spdm_pkg::IN_DATA_W-1:0]        s_tdata,
    // From bit 0: action[1:0].
    input  wire logic [1:0]                            s_tuser,
    // Result stream.
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // From bit 0: mosi, sclk, csb, mux_pin, read_word[15:0], read_valid,
    // want_data, busy_res, zero pad.
    output logic [spdm_pkg::OUT_DATA_W-1:0]            m_tdata,
    // From bit 0: status[1:0].
    output logic [1:0]                                 m_tuser,
    // Configuration writes.
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [spdm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [spdm_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import spdm_pkg::*;

    // Configuration registers.
    logic [PERIOD_W-1:0]  shift_period_reg;
    logic [CMD_BITS-1:0]  cmd_read_reg;
    logic [CMD_BITS-1:0]  cmd_write_reg;
    logic                 mux_enable_reg;
    logic                 mux_config_reg;

    // Waveform state.
    logic [3:0]           pin_levels_reg, pin_levels_next;
    phase_t               phase_reg, phase_next;
    logic [PERIOD_W-1:0]  hold_reg, hold_next;
    logic [BIT_CNT_W-1:0] bit_count_reg, bit_count_next;
    logic [SEG_W-1:0]     segment_reg, segment_next;
    logic [WORD_BITS-1:0] shift_out_reg, shift_out_next;
    logic [WORD_BITS-1:0] shift_in_reg, shift_in_next;
    logic [15:0]          words_left_reg, words_left_next;
    logic [15:0]          saved_address_reg, saved_address_next;
    logic [CMD_BITS-1:0]  saved_command_reg, saved_command_next;

    // Per-transaction results of the step logic.
    logic [3:0]           slot_level;
    status_t              step_status;
    logic                 step_valid;
    logic [WORD_BITS-1:0] step_word;
    result_t              step_result;

    // Output stage.
    logic                 out_valid_reg;
    result_t              out_reg;
    logic                 skid_valid_reg;
    result_t              skid_reg;

    logic                 in_accept;
    action_t              in_action;
    in_data_t             in_data;

    assign in_accept = s_tvalid && s_tready;
    assign in_action = action_t'(s_tuser);
    assign in_data   = s_tdata[$bits(in_data_t)-1:0];

    assign s_tready  = !skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = OUT_DATA_W'(out_reg.data);
    assign m_tuser   = out_reg.status;

    // Next-state logic: advances the pin waveform for a tick, or handles a
    // start request or a write data word.
    always_comb
    begin
        logic [PERIOD_W-1:0]  period;
        logic [PERIOD_W:0]    hold_inc;
        logic                 hold_wrap;
        logic [3:0]           pl;
        logic [WORD_BITS-1:0] si;
        logic [BIT_CNT_W-1:0] bc_m1;
        logic [15:0]          wl;
        logic [WORD_BITS-1:0] echo_word;

        pin_levels_next    = pin_levels_reg;
        phase_next         = phase_reg;
        hold_next          = hold_reg;
        bit_count_next     = bit_count_reg;
        segment_next       = segment_reg;
        shift_out_next     = shift_out_reg;
        shift_in_next      = shift_in_reg;
        words_left_next    = words_left_reg;
        saved_address_next = saved_address_reg;
        saved_command_next = saved_command_reg;
        slot_level         = pin_levels_reg;
        step_status        = ST_NORMAL;
        step_valid         = 1'b0;
        step_word          = '0;

        // A period of zero behaves as a period of one.
        period    = (shift_period_reg == '0) ? PERIOD_W'(1) : shift_period_reg;
        hold_inc  = {1'b0, hold_reg} + 1'b1;
        hold_wrap = (hold_inc >= {1'b0, period});
        pl        = pin_levels_reg;
        si        = shift_in_reg;
        bc_m1     = bit_count_reg - 1'b1;
        wl        = words_left_reg - 1'b1;
        echo_word = WORD_BITS'({saved_command_reg, saved_address_reg[15:8]});

        if (in_accept)
        begin
            unique case (in_action) inside
                ACT_TICK:
                begin
                    if (phase_reg == PH_END)
                    begin
                        // Closing sequence: clock low with chip select high, then the
                        // clock is pulsed high in SEG_HIGH and again in SEG_LAST.
                        if (hold_reg == '0)
                        begin
                            if (segment_reg != SEG_SETUP)
                                pl[PIN_CSB] = 1'b1;
                            pl[PIN_CLK] = (segment_reg == SEG_HIGH) || (segment_reg == SEG_LAST);
                        end
                        slot_level      = pl;
                        pin_levels_next = pl;
                        if (hold_wrap)
                        begin
                            hold_next    = '0;
                            segment_next = segment_reg + 1'b1;
                            if (segment_reg == SEG_LAST)
                            begin
                                pin_levels_next[PIN_CLK] = 1'b0;
                                phase_next               = PH_IDLE;
                                step_status              = ST_DONE;
                            end
                        end
                        else
                        begin
                            hold_next = hold_inc[PERIOD_W-1:0];
                        end
                    end
                    else if (phase_reg != PH_IDLE && phase_reg != PH_WAIT)
                    begin
                        if (hold_reg == '0)
                        begin
                            if (segment_reg == SEG_LOW)
                            begin
                                pl[PIN_MOSI] = shift_out_reg[bc_m1[BIT_IDX_W-1:0]];
                                pl[PIN_CLK]  = 1'b0;
                            end
                            else if (segment_reg == SEG_HIGH)
                            begin
                                pl[PIN_CLK] = 1'b1;
                                si          = {si[WORD_BITS-2:0], in_data.miso};
                            end
                        end
                        slot_level      = pl;
                        pin_levels_next = pl;
                        shift_in_next   = si;
                        if (hold_wrap)
                        begin
                            hold_next = '0;
                            if (segment_reg == SEG_SETUP)
                                segment_next = SEG_LOW;
                            else if (segment_reg == SEG_LOW)
                                segment_next = SEG_HIGH;
                            else
                            begin
                                bit_count_next = bc_m1;
                                if (bc_m1 != '0)
                                    segment_next = SEG_LOW;
                                else
                                begin
                                    // Current transfer finished: move to the
                                    // next phase of the transaction.
                                    unique case (phase_reg)
                                        PH_RESET:
                                        begin
                                            if (mux_enable_reg)
                                                pin_levels_next[PIN_CSB] = 1'b0;
                                            else if (mux_config_reg)
                                            begin
                                                pin_levels_next[PIN_CSB] = 1'b1;
                                                pin_levels_next[PIN_MUX] = 1'b1;
                                            end
                                            else
                                            begin
                                                pin_levels_next[PIN_CSB] = 1'b0;
                                                pin_levels_next[PIN_MUX] = 1'b0;
                                            end
                                            phase_next     = PH_CMD;
                                            bit_count_next = BIT_CNT_W'(CMD_BITS);
                                            shift_out_next = WORD_BITS'(saved_command_reg);
                                            shift_in_next  = '0;
                                            segment_next   = SEG_SETUP;
                                        end
                                        PH_CMD:
                                        begin
                                            phase_next     = PH_ADDR;
                                            bit_count_next = BIT_CNT_W'(WORD_BITS);
                                            shift_out_next = WORD_BITS'(saved_address_reg);
                                            shift_in_next  = '0;
                                            segment_next   = SEG_SETUP;
                                        end
                                        PH_ADDR:
                                        begin
                                            if (saved_command_reg[0])
                                            begin
                                                phase_next     = PH_ECHO;
                                                bit_count_next = BIT_CNT_W'(WORD_BITS);
                                                shift_out_next = '0;
                                                shift_in_next  = '0;
                                                segment_next   = SEG_SETUP;
                                            end
                                            else if (words_left_reg == '0)
                                            begin
                                                phase_next  = PH_IDLE;
                                                step_status = ST_DONE;
                                            end
                                            else
                                                phase_next = PH_WAIT;
                                        end
                                        PH_ECHO:
                                        begin
                                            if (si != echo_word)
                                            begin
                                                phase_next  = PH_IDLE;
                                                step_status = ST_MISMATCH;
                                            end
                                            else if (words_left_reg == '0)
                                            begin
                                                phase_next  = PH_IDLE;
                                                step_status = ST_DONE;
                                            end
                                            else
                                            begin
                                                phase_next     = PH_RDATA;
                                                bit_count_next = BIT_CNT_W'(WORD_BITS);
                                                shift_out_next = '0;
                                                shift_in_next  = '0;
                                                segment_next   = SEG_SETUP;
                                            end
                                        end
                                        PH_RDATA:
                                        begin
                                            step_valid      = 1'b1;
                                            step_word       = si;
                                            words_left_next = wl;
                                            if (wl == '0)
                                            begin
                                                phase_next   = PH_END;
                                                segment_next = SEG_SETUP;
                                            end
                                            else
                                            begin
                                                bit_count_next = BIT_CNT_W'(WORD_BITS);
                                                shift_out_next = '0;
                                                shift_in_next  = '0;
                                                segment_next   = SEG_SETUP;
                                            end
                                        end
                                        default:
                                        begin
                                            words_left_next = wl;
                                            if (wl == '0)
                                            begin
                                                phase_next  = PH_IDLE;
                                                step_status = ST_DONE;
                                            end
                                            else
                                                phase_next = PH_WAIT;
                                        end
                                    endcase
                                end
                            end
                        end
                        else
                        begin
                            hold_next = hold_inc[PERIOD_W-1:0];
                        end
                    end
                end
                ACT_WORD:
                begin
                    // A word is taken only while a write waits for one.
                    if (phase_reg == PH_WAIT)
                    begin
                        phase_next     = PH_WDATA;
                        bit_count_next = BIT_CNT_W'(WORD_BITS);
                        shift_out_next = WORD_BITS'(in_data.data);
                        shift_in_next  = '0;
                        segment_next   = SEG_SETUP;
                        hold_next      = '0;
                    end
                end
                ACT_READ, ACT_WRITE:
                begin
                    if (phase_reg != PH_IDLE)
                        step_status = ST_BUSY;
                    else
                    begin
                        if (in_action == ACT_READ)
                            saved_command_next = {cmd_read_reg[CMD_BITS-1:2], CMD_READ_TAG};
                        else
                            saved_command_next = {cmd_write_reg[CMD_BITS-1:2], CMD_WRITE_TAG};
                        saved_address_next       = in_data.address;
                        words_left_next          = in_data.length;
                        pin_levels_next[PIN_CSB] = 1'b1;
                        if (!mux_enable_reg)
                            pin_levels_next[PIN_MUX] = 1'b0;
                        phase_next     = PH_RESET;
                        bit_count_next = BIT_CNT_W'(RESET_PULSES);
                        shift_out_next = '0;
                        shift_in_next  = '0;
                        segment_next   = SEG_SETUP;
                        hold_next      = '0;
                    end
                    slot_level = pin_levels_next;
                end
            endcase
        end
    end

    // Result assembly from the step logic.
    always_comb
    begin
        step_result.status          = step_status;
        step_result.data.mosi       = slot_level[PIN_MOSI];
        step_result.data.sclk       = slot_level[PIN_CLK];
        step_result.data.csb        = slot_level[PIN_CSB];
        step_result.data.mux_pin    = slot_level[PIN_MUX];
        step_result.data.read_word  = 16'(step_word);
        step_result.data.read_valid = step_valid;
        step_result.data.want_data  = (phase_next == PH_WAIT);
        step_result.data.busy_res   = (phase_next != PH_IDLE);
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_period_reg <= SHIFT_PERIOD_RESET;
            cmd_read_reg     <= '0;
            cmd_write_reg    <= '0;
            mux_enable_reg   <= 1'b0;
            mux_config_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SHIFT_PERIOD: shift_period_reg <= cfg_data;
                CFG_CMD_READ:     cmd_read_reg     <= cfg_data;
                CFG_CMD_WRITE:    cmd_write_reg    <= cfg_data;
                CFG_MUX_ENABLE:   mux_enable_reg   <= cfg_data[0];
                CFG_MUX_CONFIG:   mux_config_reg   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Waveform state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_levels_reg    <= 4'hF;
            phase_reg         <= PH_IDLE;
            hold_reg          <= '0;
            bit_count_reg     <= '0;
            segment_reg       <= SEG_SETUP;
            shift_out_reg     <= '0;
            shift_in_reg      <= '0;
            words_left_reg    <= '0;
            saved_address_reg <= '0;
            saved_command_reg <= '0;
        end
        else
        begin
            pin_levels_reg    <= pin_levels_next;
            phase_reg         <= phase_next;
            hold_reg          <= hold_next;
            bit_count_reg     <= bit_count_next;
            segment_reg       <= segment_next;
            shift_out_reg     <= shift_out_next;
            shift_in_reg      <= shift_in_next;
            words_left_reg    <= words_left_next;
            saved_address_reg <= saved_address_next;
            saved_command_reg <= saved_command_next;
        end
    end

    // Output stage valid bits. The skid register fills only when the output
    // register is held by the consumer; it drains first when that clears.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= in_accept;
        end
        else if (in_accept)
            skid_valid_reg <= 1'b1;
    end

    // Output stage payload.
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (in_accept)
                out_reg <= step_result;
        end
        else if (in_accept)
            skid_reg <= step_result;
    end

endmodule

`default_nettype wire

>>> sv/spdm_checker.sv
// Port-level checks for the SPI debug port master, bound to the top level.
`default_nettype none

`include "spi_debug_port_master_core_defines.svh"

module spdm_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [spdm_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  wire logic [1:0]                       m_tuser
);

    import spdm_pkg::*;

    out_data_t od;
    logic      in_seen;

    assign od      = m_tdata[$bits(out_data_t)-1:0];
    assign in_seen = s_tvalid && s_tready;

    `SDPM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `SDPM_ASSERT_NOW(a_stall_only_when_full, !s_tready, m_tvalid, "input stalled with empty output")
    `SDPM_ASSERT_NOW(a_read_word_busy, m_tvalid && od.read_valid, od.busy_res && (m_tuser == ST_NORMAL), "read word outside a running read")
    `SDPM_ASSERT_NOW(a_end_idle, m_tvalid && (m_tuser == ST_DONE || m_tuser == ST_MISMATCH), !od.busy_res && !od.want_data, "ended transaction still busy")
    `SDPM_ASSERT_NEXT(a_accept_result, in_seen, m_tvalid, "accepted item produced no result")

endmodule

bind spi_debug_port_master_core spdm_checker u_spdm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
